// ===== src/assert_macros.svh =====
// assertion macros for the weighted profile distance checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define WPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define WPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wpd_pkg.sv =====
// types, constants and sizes for the weighted profile distance block
// used by wpd_div, weighted_profile_distance_core and wpd_checker
package wpd_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int MAX_LENGTHS = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int CNT_W       = $clog2(MAX_LENGTHS + 1);

  localparam logic [15:0] VALUE_MASK =
    (VALUE_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << VALUE_WIDTH) - 32'd1);

  localparam int DVD_W   = 64;
  localparam int DSR_W   = 48;
  localparam int STEP_W  = $clog2(DVD_W + 1);
  localparam logic [STEP_W-1:0] TERM_STEPS  = STEP_W'(48);
  localparam logic [STEP_W-1:0] FINAL_STEPS = STEP_W'(DVD_W);

  typedef struct packed {
    logic [15:0] median_first;
    logic [15:0] median_second;
    logic [15:0] spread_first;
    logic [15:0] spread_second;
    logic        last_length;
  } wpd_in_t;

  typedef struct packed {
    logic [47:0] distance;
    logic        saturated;
  } wpd_out_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } wpd_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wpd_div_rsp_t;

endpackage

// ===== src/wpd_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on wpd_pkg for widths and the request and response structs
module wpd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wpd_pkg::wpd_div_req_t      req_i,
  input  logic [wpd_pkg::DVD_W-1:0]  dividend_i,
  input  logic [wpd_pkg::DSR_W-1:0]  divisor_i,
  output wpd_pkg::wpd_div_rsp_t      rsp_o,
  output logic [wpd_pkg::DVD_W-1:0]  quotient_o
);

  logic [wpd_pkg::DVD_W-1:0]  dvd_q;
  logic [wpd_pkg::DSR_W-1:0]  dsr_q;
  logic [wpd_pkg::DSR_W-1:0]  rem_q;
  logic [wpd_pkg::DVD_W-1:0]  quo_q;
  logic [wpd_pkg::STEP_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic [wpd_pkg::DSR_W:0]    rem_sh;
  logic [wpd_pkg::DSR_W:0]    rem_sub;
  logic                       fits;

  assign rem_sh  = {rem_q, dvd_q[wpd_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign fits    = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= req_i.steps;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[wpd_pkg::DVD_W-2:0], 1'b0};
        rem_q <= fits ? rem_sub[wpd_pkg::DSR_W-1:0] : rem_sh[wpd_pkg::DSR_W-1:0];
        quo_q <= {quo_q[wpd_pkg::DVD_W-2:0], fits};
        cnt_q <= cnt_q - wpd_pkg::STEP_W'(1);
        if (cnt_q == wpd_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/weighted_profile_distance_core.sv =====
// top level of the weighted profile distance block: sequencer, squarer, accumulators
// depends on wpd_pkg and instantiates wpd_div
//
// usage:
//   input channel in_valid_i/in_ready_o carries one sample (two medians, two
//   deviations, last flag) per transfer. output channel out_valid_o/out_ready_i
//   carries the distance in unsigned Q32.16 and the saturated flag.
//   a sample passes through the accept step, the shared 16x16 squarer for the
//   two medians and two deviations, the weight step, the divider load, the
//   48 quotient bits of the scaled term, the done flag and the accumulate step.
//   a final sample (last flag, or the MAX_LENGTHS-th since the last result) adds
//   a start step, a divider load, the 64 quotient bits of term_sum/weight_sum,
//   the done flag and the output load. in_ready_o is high only while no
//   sample is in work.
//   the result sits in an output register; the next pair's samples are taken
//   while it waits. only the next result waits for a stalled receiver.
//   reset clears the sums, the saturation flag, the length count and the
//   output valid; no clearing pass is needed.
module weighted_profile_distance_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wpd_pkg::wpd_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wpd_pkg::wpd_out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WGT,
    ST_TDIV,
    ST_ACC,
    ST_FSTART,
    ST_FDIV,
    ST_OUT
  } state_e;

  localparam logic [63:0] TERM_MAX = {64{1'b1}};
  localparam logic [47:0] W48_MAX  = {48{1'b1}};

  state_e                    state_q;
  logic [1:0]                mul_sel_q;
  logic [15:0]               mf_q, ms_q, sf_q, ss_q;
  logic                      last_q;
  logic [31:0]               sqf_q, sqs_q, sqsf_q, sqss_q;
  logic [32:0]               w_q;
  logic [63:0]               term_sum_q;
  logic [47:0]               weight_sum_q;
  logic                      ovf_q;
  logic [wpd_pkg::CNT_W-1:0] cnt_q;
  logic                      out_valid_q;
  wpd_pkg::wpd_out_t         out_q;

  wpd_pkg::wpd_div_req_t     div_req_q;
  logic [wpd_pkg::DVD_W-1:0] div_dvd_q;
  logic [wpd_pkg::DSR_W-1:0] div_dsr_q;
  wpd_pkg::wpd_div_rsp_t     div_rsp;
  logic [wpd_pkg::DVD_W-1:0] div_quo;

  logic [15:0]               mul_op;
  logic [31:0]               mul_prod;
  logic [31:0]               diff;
  logic [32:0]               weight;
  logic [64:0]               term_add;
  logic [48:0]               wsum_add;
  logic [wpd_pkg::CNT_W-1:0] cnt_next;
  logic                      out_free;

  wpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (div_dsr_q),
    .rsp_o      (div_rsp),
    .quotient_o (div_quo)
  );

  always_comb begin
    case (mul_sel_q)
      2'd0:    mul_op = mf_q;
      2'd1:    mul_op = ms_q;
      2'd2:    mul_op = sf_q;
      default: mul_op = ss_q;
    endcase
  end

  assign mul_prod = 32'(mul_op) * 32'(mul_op);
  assign diff     = (sqf_q >= sqs_q) ? (sqf_q - sqs_q) : (sqs_q - sqf_q);
  assign weight   = (sf_q == '0 && ss_q == '0) ? 33'd1 : (33'(sqsf_q) + 33'(sqss_q));
  assign term_add = 65'(term_sum_q) + 65'(div_quo[47:0]);
  assign wsum_add = 49'(weight_sum_q) + 49'(w_q);
  assign cnt_next = cnt_q + wpd_pkg::CNT_W'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mul_sel_q    <= '0;
      mf_q         <= '0;
      ms_q         <= '0;
      sf_q         <= '0;
      ss_q         <= '0;
      last_q       <= 1'b0;
      sqf_q        <= '0;
      sqs_q        <= '0;
      sqsf_q       <= '0;
      sqss_q       <= '0;
      w_q          <= '0;
      term_sum_q   <= '0;
      weight_sum_q <= '0;
      ovf_q        <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      div_req_q    <= '0;
      div_dvd_q    <= '0;
      div_dsr_q    <= '0;
    end else begin
      div_req_q.start <= (state_q == ST_WGT) || (state_q == ST_FSTART);
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mf_q      <= in_data_i.median_first & wpd_pkg::VALUE_MASK;
            ms_q      <= in_data_i.median_second & wpd_pkg::VALUE_MASK;
            sf_q      <= in_data_i.spread_first & wpd_pkg::VALUE_MASK;
            ss_q      <= in_data_i.spread_second & wpd_pkg::VALUE_MASK;
            last_q    <= in_data_i.last_length;
            mul_sel_q <= '0;
            state_q   <= ST_MUL;
          end
        end
        ST_MUL: begin
          case (mul_sel_q)
            2'd0:    sqf_q  <= mul_prod;
            2'd1:    sqs_q  <= mul_prod;
            2'd2:    sqsf_q <= mul_prod;
            default: sqss_q <= mul_prod;
          endcase
          mul_sel_q <= mul_sel_q + 2'd1;
          if (mul_sel_q == 2'd3) begin
            state_q <= ST_WGT;
          end
        end
        ST_WGT: begin
          w_q             <= weight;
          div_dvd_q       <= {diff, 32'd0};
          div_dsr_q       <= 48'(weight);
          div_req_q.steps <= wpd_pkg::TERM_STEPS;
          state_q         <= ST_TDIV;
        end
        ST_TDIV: begin
          if (div_rsp.done) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (term_add[64]) begin
            term_sum_q <= TERM_MAX;
          end else begin
            term_sum_q <= term_add[63:0];
          end
          if (wsum_add[48]) begin
            weight_sum_q <= W48_MAX;
          end else begin
            weight_sum_q <= wsum_add[47:0];
          end
          ovf_q <= ovf_q | term_add[64] | wsum_add[48];
          if (last_q || cnt_next >= wpd_pkg::CNT_W'(wpd_pkg::MAX_LENGTHS)) begin
            state_q <= ST_FSTART;
          end else begin
            cnt_q   <= cnt_next;
            state_q <= ST_IDLE;
          end
        end
        ST_FSTART: begin
          div_dvd_q       <= term_sum_q;
          div_dsr_q       <= weight_sum_q;
          div_req_q.steps <= wpd_pkg::FINAL_STEPS;
          state_q         <= ST_FDIV;
        end
        ST_FDIV: begin
          if (div_rsp.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            if (weight_sum_q == '0) begin
              out_q.distance  <= '0;
              out_q.saturated <= ovf_q;
            end else if (div_quo[63:48] != '0) begin
              out_q.distance  <= W48_MAX;
              out_q.saturated <= 1'b1;
            end else begin
              out_q.distance  <= div_quo[47:0];
              out_q.saturated <= ovf_q;
            end
            term_sum_q   <= '0;
            weight_sum_q <= '0;
            ovf_q        <= 1'b0;
            cnt_q        <= '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/wpd_checker.sv =====
// port-level checker for weighted_profile_distance_core, bound to the top level
// depends on wpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module wpd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input wpd_pkg::wpd_out_t out_data_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  `WPD_ASSERT_NEXT(a_out_valid_holds, out_valid_i && !out_ready_i, out_valid_i, "result dropped before transfer")
  `WPD_ASSERT_NEXT(a_out_data_holds, out_valid_i && !out_ready_i, $stable(out_data_i), "result changed while stalled")
  `WPD_ASSERT_NEXT(a_busy_after_take, in_xfer, !in_ready_i, "sample taken while previous still in work")
  `WPD_ASSERT_SAME(a_result_from_work, $rose(out_valid_i), $past(!in_ready_i), "result appeared without work in progress")

endmodule

bind weighted_profile_distance_core wpd_checker u_wpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
